// ===== design/eprof_pkg.sv =====
// shared types and constants for the execution time profiler
// no dependencies; used by every module of the block
package eprof_pkg;

	localparam int SEGMENTS   = 16;
	localparam int TIME_WIDTH = 32;
	localparam int SEG_AW     = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int SHIFT_W    = 5;

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [SEG_AW-1:0]     seg_idx_t;
	typedef logic [SHIFT_W-1:0]    shift_t;

	typedef enum logic {
		KIND_ENTER = 1'b0,
		KIND_LEAVE = 1'b1
	} kind_t;

	// per-segment statistics word as stored in the statistics memory
	typedef struct packed {
		time_t average;
		time_t minimum;
		time_t maximum;
	} stat_t;

endpackage

// ===== design/eprof_stamp_mem.sv =====
// enter timestamp memory, one entry per segment, registered read
// depends on eprof_pkg; entries never written read as zero
module eprof_stamp_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  eprof_pkg::seg_idx_t wr_addr,
	input  eprof_pkg::time_t    wr_data,
	input  logic                rd_en,
	input  eprof_pkg::seg_idx_t rd_addr,
	output eprof_pkg::time_t    rd_data
);

	eprof_pkg::time_t               mem [eprof_pkg::SEGMENTS];
	logic [eprof_pkg::SEGMENTS-1:0] written_q;
	eprof_pkg::time_t               rd_data_q;
	logic                           rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_data_q : '0;

endmodule

// ===== design/eprof_stat_mem.sv =====
// statistics memory (average, minimum, maximum) with per-segment first flags
// depends on eprof_pkg; registered read
module eprof_stat_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  eprof_pkg::seg_idx_t wr_addr,
	input  eprof_pkg::stat_t    wr_data,
	input  logic                rd_en,
	input  eprof_pkg::seg_idx_t rd_addr,
	output eprof_pkg::stat_t    rd_data,
	output logic                rd_first
);

	eprof_pkg::stat_t               mem [eprof_pkg::SEGMENTS];
	logic [eprof_pkg::SEGMENTS-1:0] seen_q;
	eprof_pkg::stat_t               rd_data_q;
	logic                           rd_seen_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// a segment stays first-pending until its statistics are first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			rd_seen_q <= 1'b0;
		end else begin
			if (wr_en) begin
				seen_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_seen_q <= seen_q[rd_addr];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_first = !rd_seen_q;

endmodule

// ===== design/eprof_update.sv =====
// elapsed time and statistics update: subtract, min/max compare, average step
// depends on eprof_pkg; purely combinational
module eprof_update (
	input  eprof_pkg::time_t  leave_stamp,
	input  eprof_pkg::time_t  enter_stamp,
	input  logic              first,
	input  eprof_pkg::stat_t  old_stat,
	input  eprof_pkg::shift_t average_shift,
	output eprof_pkg::time_t  elapsed,
	output eprof_pkg::stat_t  new_stat
);

	eprof_pkg::time_t el;
	eprof_pkg::time_t avg_base;
	eprof_pkg::time_t step;

	always_comb begin
		el       = leave_stamp - enter_stamp;
		new_stat = old_stat;
		if (first) begin
			new_stat.minimum = el;
			new_stat.maximum = el;
			avg_base         = el;
		end else begin
			avg_base = old_stat.average;
			// minimum has priority; maximum only checked when minimum holds
			if (el < old_stat.minimum) begin
				new_stat.minimum = el;
			end else if (el > old_stat.maximum) begin
				new_stat.maximum = el;
			end
		end
		if (avg_base < el) begin
			step             = (el - avg_base) >> average_shift;
			new_stat.average = avg_base + step;
		end else begin
			step             = (avg_base - el) >> average_shift;
			new_stat.average = avg_base - step;
		end
	end

	assign elapsed = el;

endmodule

// ===== design/execution_time_profiler.sv =====
// execution time profiler top level: request decode, memories, result register
// depends on eprof_pkg, eprof_stamp_mem, eprof_stat_mem, eprof_update
//
// channel   ports                                         handshake
// request   kind, segment, timestamp                      start & !busy
// result    out_segment, elapsed_time, average_time,      result_strobe, one cycle
//           minimum_time, maximum_time
// config    cfg_data (average_shift)                      cfg_valid & cfg_ready
//
// an enter request leaves busy low, and the next request follows at once.
// a leave request reads both memories at the accepting edge, updates while busy is high
// and writes back at the edge that ends busy; no request is accepted while busy.
// the result strobe is high in the cycle after busy; the receiver cannot stall.
// reset clears the first flags and the enter-stamp valid bits; no clearing pass.
module execution_time_profiler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [3:0]  segment,
	input  logic [31:0] timestamp,
	output logic        result_strobe,
	output logic [3:0]  out_segment,
	output logic [31:0] elapsed_time,
	output logic [31:0] average_time,
	output logic [31:0] minimum_time,
	output logic [31:0] maximum_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	logic                accept;
	logic                in_range;
	logic                leave_req;
	logic                enter_req;
	eprof_pkg::seg_idx_t seg_idx;
	eprof_pkg::time_t    stamp_in;

	eprof_pkg::shift_t   shift_q;
	logic                busy_q;
	eprof_pkg::seg_idx_t idx_s1;
	logic [3:0]          seg_s1;
	eprof_pkg::time_t    stamp_s1;

	eprof_pkg::time_t    enter_rd;
	eprof_pkg::stat_t    stat_rd;
	logic                first_rd;
	eprof_pkg::time_t    elapsed;
	eprof_pkg::stat_t    new_stat;

	logic                strobe_q;
	logic [3:0]          seg_s2;
	eprof_pkg::time_t    elapsed_s2;
	eprof_pkg::stat_t    stat_s2;

	assign accept    = start && !busy_q;
	assign in_range  = 32'(segment) < eprof_pkg::SEGMENTS;
	assign leave_req = accept && in_range && (kind == eprof_pkg::KIND_LEAVE);
	assign enter_req = accept && in_range && (kind == eprof_pkg::KIND_ENTER);
	assign seg_idx   = eprof_pkg::SEG_AW'(segment);
	assign stamp_in  = eprof_pkg::TIME_WIDTH'(timestamp);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= eprof_pkg::shift_t'(4);
			busy_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				shift_q <= cfg_data;
			end
			busy_q   <= leave_req;
			strobe_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_req) begin
			idx_s1   <= seg_idx;
			seg_s1   <= segment;
			stamp_s1 <= stamp_in;
		end
		if (busy_q) begin
			seg_s2     <= seg_s1;
			elapsed_s2 <= elapsed;
			stat_s2    <= new_stat;
		end
	end

	eprof_stamp_mem u_stamp_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (enter_req),
		.wr_addr (seg_idx),
		.wr_data (stamp_in),
		.rd_en   (leave_req),
		.rd_addr (seg_idx),
		.rd_data (enter_rd)
	);

	// write-back lands before the next leave can read, so no forwarding
	eprof_stat_mem u_stat_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (busy_q),
		.wr_addr  (idx_s1),
		.wr_data  (new_stat),
		.rd_en    (leave_req),
		.rd_addr  (seg_idx),
		.rd_data  (stat_rd),
		.rd_first (first_rd)
	);

	eprof_update u_update (
		.leave_stamp   (stamp_s1),
		.enter_stamp   (enter_rd),
		.first         (first_rd),
		.old_stat      (stat_rd),
		.average_shift (shift_q),
		.elapsed       (elapsed),
		.new_stat      (new_stat)
	);

	assign busy          = busy_q;
	assign result_strobe = strobe_q;
	assign out_segment   = seg_s2;
	assign elapsed_time  = 32'(elapsed_s2);
	assign average_time  = 32'(stat_s2.average);
	assign minimum_time  = 32'(stat_s2.minimum);
	assign maximum_time  = 32'(stat_s2.maximum);

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("busy held longer than one cycle");

	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(busy_q))
		else $error("result strobe without a leave update");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> (stat_s2.minimum <= stat_s2.maximum))
		else $error("minimum above maximum");

	a_avg_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> (stat_s2.average >= stat_s2.minimum && stat_s2.average <= stat_s2.maximum))
		else $error("average outside minimum and maximum");

endmodule
